// ===== hw/rtl/drd_pkg.sv =====
// Shared types and constants for the detection row decoder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package drd_pkg;

    localparam int MAX_CLASSES = 128;
    localparam int MIN_ROW_LEN = 6;
    localparam int MAX_IMG     = 8192;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 17;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LAYOUT_MODE = 3'd0,
        CFG_CLASS_COUNT = 3'd1,
        CFG_ROW_LENGTH  = 3'd2,
        CFG_CONF_THR    = 3'd3,
        CFG_SCORE_THR   = 3'd4,
        CFG_IMAGE_W     = 3'd5,
        CFG_IMAGE_H     = 3'd6
    } t_cfg_idx;

    // Layout modes
    localparam logic MODE_OBJECTNESS = 1'b0;
    localparam logic MODE_CLASSES    = 1'b1;

    // Effective configuration, already clamped to legal ranges
    typedef struct packed {
        logic        mode;
        logic [7:0]  row_len;
        logic [7:0]  ncls;
        logic [16:0] conf_thr;
        logic [16:0] score_thr;
        logic [13:0] img_w;
        logic [13:0] img_h;
    } t_cfg;

    // One finished row handed from the front to the back
    typedef struct packed {
        logic [15:0]       row_idx;
        logic [6:0]        cls;
        logic [31:0]       best;
        logic [31:0]       obj;
        logic [3:0][31:0]  box;
    } t_row_rec;

endpackage

`default_nettype wire

// ===== hw/rtl/drd_front.sv =====
// Front end: accepts tensor beats, tracks position, box, objectness and best class.
// Depends on drd_pkg; pushes one record per finished row into the row queue.
`default_nettype none

module drd_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire drd_pkg::t_cfg     i_cfg,
    input  wire logic              i_valid,
    input  wire logic [31:0]       i_value,
    input  wire logic              i_frame_start,
    input  wire logic              i_full,
    output logic                   o_push,
    output drd_pkg::t_row_rec      o_rec
);
    import drd_pkg::*;

    logic [7:0]        r_pos;
    logic [16:0]       r_row;
    logic [3:0][31:0]  r_box;
    logic [31:0]       r_obj;
    logic [31:0]       r_best;
    logic [6:0]        r_cls;

    logic [7:0]        n_pos;
    logic [16:0]       n_row;
    logic [3:0][31:0]  n_box;
    logic [31:0]       n_obj;
    logic [31:0]       n_best;
    logic [6:0]        n_cls;

    logic              accept;
    logic              row_act;
    logic [7:0]        pos;
    logic [16:0]       rowc;
    logic [7:0]        off;
    logic [7:0]        cdiff;
    logic [8:0]        pos_inc;
    logic              row_end;

    assign accept  = i_valid && !i_full;
    assign pos     = i_frame_start ? 8'd0 : r_pos;
    assign rowc    = i_frame_start ? 17'd0 : r_row;
    assign row_act = !rowc[16];
    assign off     = (i_cfg.mode == MODE_CLASSES) ? 8'd4 : 8'd5;
    assign cdiff   = pos - off;
    assign pos_inc = {1'b0, pos} + 9'd1;
    assign row_end = !(pos_inc < {1'b0, i_cfg.row_len});

    // Update row state for the beat at the current position
    always_comb begin
        n_pos  = r_pos;
        n_row  = r_row;
        n_box  = r_box;
        n_obj  = r_obj;
        n_best = r_best;
        n_cls  = r_cls;
        o_push = 1'b0;
        if (accept) begin
            n_pos = pos;
            n_row = rowc;
            if (row_act) begin
                if (pos < 8'd4) begin
                    n_box[pos[1:0]] = i_value;
                end else if (pos == 8'd4 && i_cfg.mode == MODE_OBJECTNESS) begin
                    n_obj = i_value;
                end
                if (pos == off) begin
                    n_best = i_value;
                    n_cls  = 7'd0;
                end else if (pos > off && cdiff < i_cfg.ncls
                             && $signed(i_value) > $signed(r_best)) begin
                    n_best = i_value;
                    n_cls  = cdiff[6:0];
                end
                if (row_end) begin
                    n_pos  = 8'd0;
                    n_row  = rowc + 17'd1;
                    o_push = 1'b1;
                end else begin
                    n_pos = pos_inc[7:0];
                end
            end
        end
    end

    // Record of the finished row, including this beat's updates
    always_comb begin
        o_rec.row_idx = rowc[15:0];
        o_rec.cls     = n_cls;
        o_rec.best    = n_best;
        o_rec.obj     = n_obj;
        o_rec.box     = n_box;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_row  <= '0;
            r_box  <= '0;
            r_obj  <= '0;
            r_best <= '0;
            r_cls  <= '0;
        end else begin
            r_pos  <= n_pos;
            r_row  <= n_row;
            r_box  <= n_box;
            r_obj  <= n_obj;
            r_best <= n_best;
            r_cls  <= n_cls;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/drd_queue.sv =====
// Short row queue between the front end and the back end.
// Depends on drd_pkg for the record type and the queue depth.
`default_nettype none

module drd_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire drd_pkg::t_row_rec i_rec,
    input  wire logic              i_pop,
    output logic                   o_full,
    output logic                   o_empty,
    output drd_pkg::t_row_rec      o_rec
);
    import drd_pkg::*;

    t_row_rec              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr;
    logic [QUEUE_AW:0]     r_count;

    assign o_full  = (r_count == QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rec   = r_mem[r_rd_ptr];

    // Store pushed rows
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (QUEUE_AW+1)'(i_push) - (QUEUE_AW+1)'(i_pop);
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/drd_back.sv =====
// Back end: score product, thresholds, box conversion and the result register.
// Depends on drd_pkg; pops finished rows from the row queue.
`default_nettype none

module drd_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire drd_pkg::t_cfg     i_cfg,
    input  wire logic              i_empty,
    input  wire drd_pkg::t_row_rec i_rec,
    output logic                   o_pop,
    input  wire logic              i_stall,
    output logic                   o_valid,
    output logic [15:0]            o_row_index,
    output logic [6:0]             o_label,
    output logic [31:0]            o_score,
    output logic [12:0]            o_box_left,
    output logic [12:0]            o_box_top,
    output logic [13:0]            o_box_width,
    output logic [13:0]            o_box_height
);
    import drd_pkg::*;

    // Stage 1 registers
    logic               r_s1_valid;
    logic [15:0]        r_s1_row;
    logic [6:0]         r_s1_cls;
    logic [31:0]        r_s1_best;
    logic [31:0]        r_s1_obj;
    logic signed [63:0] r_s1_prod;
    logic [15:0]        r_s1_xs;
    logic [15:0]        r_s1_xl;
    logic [15:0]        r_s1_ys;
    logic [15:0]        r_s1_yl;

    // Result register
    logic               r_o_valid;
    logic [15:0]        r_o_row;
    logic [6:0]         r_o_cls;
    logic [31:0]        r_o_score;
    logic [12:0]        r_o_left;
    logic [12:0]        r_o_top;
    logic [13:0]        r_o_w;
    logic [13:0]        r_o_h;

    logic out_ready;
    logic s1_ready;

    assign out_ready = !r_o_valid || !i_stall;
    assign s1_ready  = !r_s1_valid || out_ready;
    assign o_pop     = !i_empty && s1_ready;

    // Start and length in whole pixels of one axis, before the image clamp
    function automatic logic [31:0] axis_raw(input logic [31:0] c, input logic [31:0] s);
        logic signed [33:0] twice;
        logic [15:0]        st;
        logic [15:0]        ln;
        twice = ($signed({{2{c[31]}}, c}) <<< 1) - $signed({{2{s[31]}}, s});
        st = (!twice[33] && twice != '0) ? twice[32:17] : 16'd0;
        ln = (!s[31] && s != '0) ? {1'b0, s[30:16]} : 16'd0;
        return {st, ln};
    endfunction

    // Clamp one axis to the image: {start[12:0], len[13:0]}
    function automatic logic [26:0] axis_clamp(input logic [15:0] st, input logic [15:0] ln,
                                               input logic [13:0] img);
        logic [16:0] sum;
        logic [13:0] len_c;
        logic [12:0] st_c;
        sum = {1'b0, st} + {1'b0, ln};
        if (sum >= {3'b0, img}) begin
            if ({2'b0, img} > st) begin
                len_c = img - st[13:0];
            end else begin
                len_c = 14'd0;
            end
        end else begin
            len_c = ln[13:0];
        end
        st_c = (st > 16'd8191) ? 13'd8191 : st[12:0];
        return {st_c, len_c};
    endfunction

    logic [31:0] x_raw;
    logic [31:0] y_raw;

    assign x_raw = axis_raw(i_rec.box[0], i_rec.box[2]);
    assign y_raw = axis_raw(i_rec.box[1], i_rec.box[3]);

    // Stage 1: multiply and raw box extents
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_row  <= i_rec.row_idx;
            r_s1_cls  <= i_rec.cls;
            r_s1_best <= i_rec.best;
            r_s1_obj  <= i_rec.obj;
            r_s1_prod <= $signed(i_rec.best) * $signed(i_rec.obj);
            r_s1_xs   <= x_raw[31:16];
            r_s1_xl   <= x_raw[15:0];
            r_s1_ys   <= y_raw[31:16];
            r_s1_yl   <= y_raw[15:0];
        end
    end

    // Stage 2: scale, saturate, threshold, clamp
    logic [31:0] score_mul;
    logic [31:0] score;
    logic        keep;
    logic [26:0] x_clamped;
    logic [26:0] y_clamped;

    always_comb begin
        if (r_s1_prod[63:47] == '0 || r_s1_prod[63:47] == '1) begin
            score_mul = r_s1_prod[47:16];
        end else if (r_s1_prod[63]) begin
            score_mul = 32'h8000_0000;
        end else begin
            score_mul = 32'h7FFF_FFFF;
        end
        if (i_cfg.mode == MODE_OBJECTNESS) begin
            score = score_mul;
        end else begin
            score = r_s1_best;
        end
        keep = $signed(score) >= $signed({15'b0, i_cfg.score_thr});
        if (i_cfg.mode == MODE_OBJECTNESS
            && $signed(r_s1_obj) < $signed({15'b0, i_cfg.conf_thr})) begin
            keep = 1'b0;
        end
    end

    assign x_clamped = axis_clamp(r_s1_xs, r_s1_xl, i_cfg.img_w);
    assign y_clamped = axis_clamp(r_s1_ys, r_s1_yl, i_cfg.img_h);

    // Result register: hold while stalled, drop rows that fail a threshold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_ready) begin
            r_o_valid <= r_s1_valid && keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_s1_valid) begin
            r_o_row   <= r_s1_row;
            r_o_cls   <= r_s1_cls;
            r_o_score <= score;
            r_o_left  <= x_clamped[26:14];
            r_o_w     <= x_clamped[13:0];
            r_o_top   <= y_clamped[26:14];
            r_o_h     <= y_clamped[13:0];
        end
    end

    assign o_valid      = r_o_valid;
    assign o_row_index  = r_o_row;
    assign o_label      = r_o_cls;
    assign o_score      = r_o_score;
    assign o_box_left   = r_o_left;
    assign o_box_top    = r_o_top;
    assign o_box_width  = r_o_w;
    assign o_box_height = r_o_h;

endmodule

`default_nettype wire

// ===== hw/rtl/detection_row_decoder.sv =====
// Detection row decoder: throughput one tensor element per cycle while o_stall is low.
// A kept row's result passes the row queue, stage 1 and the result register to o_valid.
// The input stalls only while the four-row queue to the back end is full.
// Synchronous active-low reset restores the default registers, clears position
// and row counters, running maximum and all valid flags; no clearing pass.
// Depends on drd_pkg, drd_front, drd_queue and drd_back.
`default_nettype none

module detection_row_decoder (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [drd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [drd_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [31:0]                         i_value,
    input  wire logic                                i_frame_start,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [15:0]                              o_row_index,
    output logic [6:0]                               o_label,
    output logic [31:0]                              o_score,
    output logic [12:0]                              o_box_left,
    output logic [12:0]                              o_box_top,
    output logic [13:0]                              o_box_width,
    output logic [13:0]                              o_box_height
);
    import drd_pkg::*;

    logic        r_mode;
    logic [7:0]  r_ncls;
    logic [7:0]  r_len;
    logic [16:0] r_conf;
    logic [16:0] r_sthr;
    logic [13:0] r_img_w;
    logic [13:0] r_img_h;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_CLASSES;
            r_ncls  <= 8'd80;
            r_len   <= 8'd116;
            r_conf  <= 17'd16384;
            r_sthr  <= 17'd16384;
            r_img_w <= 14'd640;
            r_img_h <= 14'd640;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_LAYOUT_MODE: r_mode  <= i_cfg_data[0];
                CFG_CLASS_COUNT: r_ncls  <= i_cfg_data[7:0];
                CFG_ROW_LENGTH:  r_len   <= i_cfg_data[7:0];
                CFG_CONF_THR:    r_conf  <= i_cfg_data;
                CFG_SCORE_THR:   r_sthr  <= i_cfg_data;
                CFG_IMAGE_W:     r_img_w <= i_cfg_data[13:0];
                CFG_IMAGE_H:     r_img_h <= i_cfg_data[13:0];
                default: ;
            endcase
        end
    end

    // Clamp registers to their working ranges
    t_cfg cfg;

    always_comb begin
        cfg.mode      = r_mode;
        cfg.row_len   = (r_len < 8'(MIN_ROW_LEN)) ? 8'(MIN_ROW_LEN) : r_len;
        cfg.ncls      = (r_ncls == 8'd0) ? 8'd1
                      : ((r_ncls > 8'(MAX_CLASSES)) ? 8'(MAX_CLASSES) : r_ncls);
        cfg.conf_thr  = r_conf;
        cfg.score_thr = r_sthr;
        cfg.img_w     = (r_img_w == 14'd0) ? 14'd1
                      : ((r_img_w > 14'(MAX_IMG)) ? 14'(MAX_IMG) : r_img_w);
        cfg.img_h     = (r_img_h == 14'd0) ? 14'd1
                      : ((r_img_h > 14'(MAX_IMG)) ? 14'(MAX_IMG) : r_img_h);
    end

    logic     push;
    logic     pop;
    logic     full;
    logic     empty;
    t_row_rec rec_in;
    t_row_rec rec_out;

    assign o_stall = full;

    drd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_valid       (i_valid),
        .i_value       (i_value),
        .i_frame_start (i_frame_start),
        .i_full        (full),
        .o_push        (push),
        .o_rec         (rec_in)
    );

    drd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (rec_in),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_rec   (rec_out)
    );

    drd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_empty      (empty),
        .i_rec        (rec_out),
        .o_pop        (pop),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_row_index  (o_row_index),
        .o_label      (o_label),
        .o_score      (o_score),
        .o_box_left   (o_box_left),
        .o_box_top    (o_box_top),
        .o_box_width  (o_box_width),
        .o_box_height (o_box_height)
    );

endmodule

`default_nettype wire

// ===== verif/tb_detection_row_decoder.sv =====
// Self-checking testbench for detection_row_decoder: streams tensor rows, predicts kept rows.
// Depends on drd_pkg and the detection_row_decoder RTL; stands alone otherwise.
`timescale 1ns / 1ps

module tb_detection_row_decoder;
    import drd_pkg::*;

    localparam int          CLK_PERIOD     = 10;
    localparam int          REG_COUNT      = 7;
    localparam int unsigned ROW_LIMIT      = 65536;
    localparam int          RANDOM_ITEMS   = 740;
    localparam int          PHASE_ITEMS    = 80;
    localparam int          PRESSURE_ROWS  = 30;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          SETTLE_CYCLES  = 20;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam longint      SCORE_MAX      = 64'sd2147483647;
    localparam longint      SCORE_MIN      = -SCORE_MAX - 1;

    // One result beat of the block
    typedef struct packed {
        logic [15:0] row_index;
        logic [6:0]  label;
        logic [31:0] score;
        logic [12:0] box_left;
        logic [12:0] box_top;
        logic [13:0] box_width;
        logic [13:0] box_height;
    } t_kept_row;

    // Row decoder predictor plus the queue of rows it expects to come out
    class t_kept_row_board;
        bit          mode        = 1'b1;
        bit [7:0]    class_count = 8'd80;
        bit [7:0]    row_length  = 8'd116;
        bit [16:0]   conf_thr    = 17'd16384;
        bit [16:0]   score_thr   = 17'd16384;
        bit [13:0]   img_w       = 14'd640;
        bit [13:0]   img_h       = 14'd640;
        int unsigned elem_pos;
        int unsigned row_cnt;
        longint      box[4];
        longint      objectness;
        longint      best_score;
        bit [6:0]    best_class;
        t_kept_row   pending[$];
        int          errors;

        function void write_reg(input t_cfg_idx idx, input bit [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_LAYOUT_MODE: mode        = data[0];
                CFG_CLASS_COUNT: class_count = data[7:0];
                CFG_ROW_LENGTH:  row_length  = data[7:0];
                CFG_CONF_THR:    conf_thr    = data[16:0];
                CFG_SCORE_THR:   score_thr   = data[16:0];
                CFG_IMAGE_W:     img_w       = data[13:0];
                CFG_IMAGE_H:     img_h       = data[13:0];
                default: ;
            endcase
        endfunction

        // Whole-pixel start and extent of one axis, clamped to the image
        function void box_span(input longint c, input longint s, input longint img,
                               output longint start, output longint extent);
            longint twice;
            twice  = 2 * c - s;
            start  = (twice > 0) ? (twice >>> 17) : 0;
            extent = (s > 0) ? (s >>> 16) : 0;
            if (start + extent >= img) extent = img - start;
            if (extent < 0) extent = 0;
            if (start > 8191) start = 8191;
        endfunction

        // Advance the decoder by one accepted element
        function void take_element(input logic [31:0] raw, input logic frame_start);
            longint      v, score, imgw, imgh, left, top, wid, hgt;
            int unsigned span_len, ncls, offset, pos;
            t_kept_row   row;
            v        = $signed(raw);
            span_len = (row_length < MIN_ROW_LEN) ? MIN_ROW_LEN : row_length;
            ncls     = (class_count == 0) ? 1 : class_count;
            if (ncls > MAX_CLASSES) ncls = MAX_CLASSES;
            offset   = (mode == MODE_CLASSES) ? 4 : 5;
            if (frame_start) begin
                elem_pos = 0;
                row_cnt  = 0;
            end
            // drop everything past the row limit until the next frame
            if (row_cnt >= ROW_LIMIT) return;
            pos = elem_pos;
            if (pos < 4) box[pos] = v;
            else if (pos == 4 && mode == MODE_OBJECTNESS) objectness = v;
            if (pos == offset) begin
                best_score = v;
                best_class = 0;
            end else if (pos > offset && pos - offset < ncls && v > best_score) begin
                best_score = v;
                best_class = 7'(pos - offset);
            end
            if (pos + 1 < span_len) begin
                elem_pos = pos + 1;
                return;
            end
            // row end: threshold, then build the box
            elem_pos      = 0;
            row.row_index = 16'(row_cnt);
            row_cnt++;
            if (mode == MODE_OBJECTNESS) begin
                if (objectness < longint'(conf_thr)) return;
                score = (best_score * objectness) >>> 16;
                if (score > SCORE_MAX) score = SCORE_MAX;
                if (score < SCORE_MIN) score = SCORE_MIN;
            end else begin
                score = best_score;
            end
            if (score < longint'(score_thr)) return;
            imgw = (img_w == 0) ? 1 : ((img_w > MAX_IMG) ? MAX_IMG : img_w);
            imgh = (img_h == 0) ? 1 : ((img_h > MAX_IMG) ? MAX_IMG : img_h);
            box_span(box[0], box[2], imgw, left, wid);
            box_span(box[1], box[3], imgh, top, hgt);
            row.label      = best_class;
            row.score      = score[31:0];
            row.box_left   = left[12:0];
            row.box_top    = top[12:0];
            row.box_width  = wid[13:0];
            row.box_height = hgt[13:0];
            pending.insert(pending.size(), row);
        endfunction

        function void check_field(input string field, input longint want, input longint got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
            end
        endfunction

        // Compare one result beat with the oldest expected row
        function void match_result(input t_kept_row got);
            t_kept_row want;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual row %0d",
                         $time, got.row_index);
                return;
            end
            want = pending.pop_front();
            check_field("row_index", want.row_index, got.row_index);
            check_field("label", want.label, got.label);
            check_field("score", $signed(want.score), $signed(got.score));
            check_field("box_left", want.box_left, got.box_left);
            check_field("box_top", want.box_top, got.box_top);
            check_field("box_width", want.box_width, got.box_width);
            check_field("box_height", want.box_height, got.box_height);
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_stall;
    logic [31:0]           i_value;
    logic                  i_frame_start;
    logic                  o_valid;
    logic                  i_stall;
    logic [15:0]           o_row_index;
    logic [6:0]            o_label;
    logic [31:0]           o_score;
    logic [12:0]           o_box_left;
    logic [12:0]           o_box_top;
    logic [13:0]           o_box_width;
    logic [13:0]           o_box_height;

    t_kept_row_board board = new;
    int unsigned     cfg_val[REG_COUNT];
    int unsigned     idle_pct;
    int unsigned     stall_pct;
    int unsigned     hold_req;
    int unsigned     quiet_cycles;

    detection_row_decoder i_dut (.*);

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Check result beats first, then feed the accepted element to the predictor
    always @(posedge i_clk) begin : beat_monitor
        t_kept_row got;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got.row_index  = o_row_index;
                got.label      = o_label;
                got.score      = o_score;
                got.box_left   = o_box_left;
                got.box_top    = o_box_top;
                got.box_width  = o_box_width;
                got.box_height = o_box_height;
                board.match_result(got);
            end
            if (i_valid && !o_stall) board.take_element(i_value, i_frame_start);
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    initial begin : result_sink
        int unsigned hold_seen;
        int unsigned hold_left;
        hold_seen = 0;
        hold_left = 0;
        i_stall   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Abort when no beat moves on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no beat for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // Offer one element and hold it until accepted; leaves valid high
    task automatic send_beat(input logic [31:0] val, input logic frame_start);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_value       <= val;
        i_frame_start <= frame_start;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    // Stop sending and wait until every expected row has come out
    task automatic drain();
        i_valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write all registers back to back from cfg_val
    task automatic load_config();
        for (int i = 0; i < REG_COUNT; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= t_cfg_idx'(i);
            i_cfg_data  <= cfg_val[i][CFG_DATA_W-1:0];
            @(negedge i_clk);
            board.write_reg(t_cfg_idx'(i), cfg_val[i][CFG_DATA_W-1:0]);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic int unsigned row_span();
        return (cfg_val[CFG_ROW_LENGTH] < MIN_ROW_LEN) ? MIN_ROW_LEN : cfg_val[CFG_ROW_LENGTH];
    endfunction

    // Box elements in pixel range, scores around the unit value, some raw noise
    function automatic logic [31:0] element_value(input int unsigned j);
        if ($urandom_range(7) == 0) return $urandom();
        if (j < 4) return $urandom_range(32'h2000_0000);
        case ($urandom_range(3))
            0: return 32'h0001_0000;
            1: return $urandom_range(32'h4000);
            default: return $urandom_range(32'h0001_8000);
        endcase
    endfunction

    task automatic send_row(input int unsigned count, input bit new_frame);
        for (int unsigned j = 0; j < count; j++)
            send_beat(element_value(j), (j == 0 && new_frame) || $urandom_range(299) == 0);
    endtask

    function automatic void pick_config(input int unsigned phase);
        cfg_val[CFG_LAYOUT_MODE] = $urandom_range(1);
        case ($urandom_range(7))
            0: cfg_val[CFG_CLASS_COUNT] = 0;
            1: cfg_val[CFG_CLASS_COUNT] = MAX_CLASSES;
            2: cfg_val[CFG_CLASS_COUNT] = 255;
            default: cfg_val[CFG_CLASS_COUNT] = $urandom_range(1, 12);
        endcase
        cfg_val[CFG_ROW_LENGTH] = ($urandom_range(5) == 0) ? $urandom_range(5)
                                                            : $urandom_range(6, 20);
        for (int i = CFG_CONF_THR; i <= CFG_SCORE_THR; i++) begin
            case ($urandom_range(7))
                0: cfg_val[i] = 0;
                1: cfg_val[i] = 65536;
                2: cfg_val[i] = 131071;
                default: cfg_val[i] = $urandom_range(65536);
            endcase
        end
        for (int i = CFG_IMAGE_W; i <= CFG_IMAGE_H; i++) begin
            case ($urandom_range(5))
                0: cfg_val[i] = 0;
                1: cfg_val[i] = 16383;
                2: cfg_val[i] = MAX_IMG;
                default: cfg_val[i] = $urandom_range(1, 2000);
            endcase
        end
        // pin a few phases to the register extremes
        if (phase == 0) cfg_val = '{0, 1, 6, 65536, 0, MAX_IMG, 1};
        if (phase == 3) begin
            cfg_val[CFG_ROW_LENGTH]  = 255;
            cfg_val[CFG_CLASS_COUNT] = 200;
        end
    endfunction

    initial begin : stimulus
        int unsigned random_items;
        int unsigned phase_items;
        int unsigned phase;
        int unsigned count;
        bit          first;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_valid       = 1'b0;
        i_value       = '0;
        i_frame_start = 1'b0;
        idle_pct      = 0;
        stall_pct     = 0;
        hold_req      = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Objectness layout: saturated score and corner, short row length and
        // zero class count clamped, tiny and oversized image, floor rounding
        cfg_val = '{0, 0, 3, 0, 0, 0, 16383};
        load_config();
        send_beat(32'h7FFF_FFFF, 1'b1); send_beat(32'h8000_0000, 1'b0);
        send_beat(32'h7FFF_FFFF, 1'b0); send_beat(32'h8000_0000, 1'b0);
        send_beat(32'h7FFF_FFFF, 1'b0); send_beat(32'h7FFF_FFFF, 1'b0);
        send_beat(32'h0064_0000, 1'b0); send_beat(32'h00C8_0000, 1'b0);
        send_beat(32'h0032_0000, 1'b0); send_beat(32'h0050_0000, 1'b0);
        send_beat(32'h0000_8000, 1'b0); send_beat(32'h0001_8001, 1'b0);
        // negative objectness drops the row
        send_beat(32'h0000_0000, 1'b0); send_beat(32'hFFFF_0000, 1'b0);
        send_beat(32'h0000_0000, 1'b0); send_beat(32'h0000_0000, 1'b0);
        send_beat(32'h8000_0000, 1'b0); send_beat(32'h0001_0000, 1'b0);
        drain();

        // Classes-only layout: tie keeps the first class, box at the image edge
        cfg_val = '{1, 3, 7, 65536, 16384, 640, 480};
        load_config();
        send_beat(32'h0140_0000, 1'b1); send_beat(32'h00F0_0000, 1'b0);
        send_beat(32'h0280_0000, 1'b0); send_beat(32'h01E0_0000, 1'b0);
        send_beat(32'h0000_8000, 1'b0); send_beat(32'h0000_8000, 1'b0);
        send_beat(32'h0000_4000, 1'b0);
        // shrink the row length mid-row so the next element ends the row
        send_beat(32'h0000_0000, 1'b0); send_beat(32'h0000_0000, 1'b0);
        send_beat(32'h0001_0000, 1'b0); send_beat(32'h0001_0000, 1'b0);
        send_beat(32'h0000_1000, 1'b0); send_beat(32'h0002_0000, 1'b0);
        drain();
        cfg_val[CFG_ROW_LENGTH] = 6;
        load_config();
        send_beat(32'h0003_0000, 1'b0);
        // leave a partial row so the next frame start lands mid-row
        send_beat(32'hFFFF_FFFF, 1'b0); send_beat(32'h0000_0001, 1'b0);
        drain();

        // Back-pressure: receiver holds off while kept rows fill the queue
        cfg_val = '{1, 2, 6, 0, 0, 640, 640};
        load_config();
        hold_req++;
        for (int r = 0; r < PRESSURE_ROWS; r++) send_row(row_span(), r == 0);
        drain();

        // Random phases: well-formed rows with random content, some broken rows
        random_items = 0;
        phase        = 0;
        while (random_items < RANDOM_ITEMS) begin
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 55; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 55; end
                default: begin idle_pct = 13; stall_pct = 13; end
            endcase
            pick_config(phase);
            load_config();
            phase_items = 0;
            first       = 1'b1;
            while (phase_items < PHASE_ITEMS) begin
                count = ($urandom_range(11) == 0) ? $urandom_range(1, row_span() + 4)
                                                  : row_span();
                send_row(count, first || $urandom_range(9) == 0);
                phase_items += count;
                first = 1'b0;
            end
            random_items += phase_items;
            drain();
            phase++;
        end

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== detection_row_decoder.f =====
hw/rtl/drd_pkg.sv
hw/rtl/drd_front.sv
hw/rtl/drd_queue.sv
hw/rtl/drd_back.sv
hw/rtl/detection_row_decoder.sv
verif/tb_detection_row_decoder.sv
